// ----- rtl/thumbstick_dead_zone_conditioner_core_defines.svh -----
// ----------------------------------------------------------------------------
// Thumbstick dead zone conditioner assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef THUMBSTICK_DEAD_ZONE_CONDITIONER_CORE_DEFINES_SVH
`define THUMBSTICK_DEAD_ZONE_CONDITIONER_CORE_DEFINES_SVH

// assertion sampled on clk, masked while rst is high
`define TDZC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion sampled on clk, checked during reset as well
`define TDZC_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/tdzc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thumbstick dead zone conditioner package
// Shared widths, pipeline depths, register indexes and sideband types.
// ----------------------------------------------------------------------------
package tdzc_pkg;

   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_AXIAL  = 2'd1,
      MODE_RADIAL = 2'd2,
      MODE_SCALED = 2'd3
   } zone_mode_type;

   // register indexes on the csr port
   localparam logic [7:0] CSR_ZONE_MODE   = 8'd0;
   localparam logic [7:0] CSR_DEAD_ZONE   = 8'd1;
   localparam logic [7:0] CSR_LEFT_INNER  = 8'd2;
   localparam logic [7:0] CSR_RIGHT_INNER = 8'd3;

   localparam logic [14:0] DEAD_ZONE_RST   = 15'd3277;
   localparam logic [14:0] LEFT_INNER_RST  = 15'd7849;
   localparam logic [14:0] RIGHT_INNER_RST = 15'd8689;

   localparam logic [14:0] FULL_RAW     = 15'd32767;
   localparam logic [23:0] FULL_RAW_Q8  = 24'd8388352;
   localparam logic [16:0] ONE_Q15      = 17'd32768;

   // square root: one result bit per stage
   localparam int SQRT_STAGES = 24;
   localparam int SQRT_REM_W  = 27;

   // restoring divider: one quotient bit per stage
   localparam int DIV_STAGES = 17;
   localparam int DIV_NUM_W  = 41;
   localparam int DIV_DEN_W  = 25;

   // mult, sum, sqrt, prep, div, clamp, mult, prep, div, select
   localparam int STICK_LAT = 2 + SQRT_STAGES + 1 + DIV_STAGES + 3 + DIV_STAGES + 1;

   typedef struct packed {
      logic        sx;
      logic        sy;
      logic        in_zone;
      logic [16:0] a;
      logic [16:0] b;
   } side_sqrt_type;

   typedef struct packed {
      logic sx;
      logic sy;
      logic in_zone;
      logic full;
   } side_div_type;

   typedef struct packed {
      logic        sx;
      logic        sy;
      logic        in_zone;
      logic        za;
      logic        zb;
      logic        zr;
      logic [16:0] da;
      logic [16:0] db;
      logic [16:0] mag;
   } side_mode_type;

endpackage

// ----- rtl/tdzc_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// floor(sqrt(m2 * 65536)), one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module tdzc_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] m2,
   output logic [23:0] root
);
   import tdzc_pkg::*;

   logic [31:0]           m2_ff   [SQRT_STAGES];
   logic [SQRT_REM_W-1:0] rem_ff  [SQRT_STAGES];
   logic [23:0]           root_ff [SQRT_STAGES];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      logic [31:0]           m2_src;
      logic [SQRT_REM_W-1:0] rem_src;
      logic [23:0]           root_src;
      logic [1:0]            pair;
      logic [SQRT_REM_W-1:0] cur;
      logic [SQRT_REM_W-1:0] trial;
      logic                  ge;

      if (s == 0) begin : g_first
         assign m2_src   = m2;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign m2_src   = m2_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
      end

      // low 16 bits of the radicand are zero
      if (s < 16) begin : g_bits
         assign pair = m2_src[31-2*s -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      assign cur   = {rem_src[SQRT_REM_W-3:0], pair};
      assign trial = SQRT_REM_W'({root_src, 2'b01});
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            m2_ff[s]   <= m2_src;
            rem_ff[s]  <= ge ? (cur - trial) : cur;
            root_ff[s] <= {root_src[22:0], ge};
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

// ----- rtl/tdzc_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Floor quotient, one quotient bit per register stage, MSB first.
// ----------------------------------------------------------------------------
module tdzc_divider (
   input  logic                            clock,
   input  logic                            en,
   input  logic [tdzc_pkg::DIV_NUM_W-1:0]  num,
   input  logic [tdzc_pkg::DIV_DEN_W-1:0]  den,
   output logic [tdzc_pkg::DIV_STAGES-1:0] quo
);
   import tdzc_pkg::*;

   logic [DIV_NUM_W-1:0]  rem_ff [DIV_STAGES];
   logic [DIV_DEN_W-1:0]  den_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] q_ff   [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int K = DIV_STAGES - 1 - s;
      logic [DIV_NUM_W-1:0]  rem_src;
      logic [DIV_DEN_W-1:0]  den_src;
      logic [DIV_STAGES-1:0] q_src;
      logic [DIV_NUM_W:0]    sh;
      logic [DIV_NUM_W:0]    diff;
      logic                  ge;

      if (s == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign q_src   = q_ff[s-1];
      end

      // trial subtract of the shifted divisor
      assign sh   = (DIV_NUM_W+1)'(den_src) << K;
      assign ge   = {1'b0, rem_src} >= sh;
      assign diff = {1'b0, rem_src} - sh;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? diff[DIV_NUM_W-1:0] : rem_src;
            den_ff[s] <= den_src;
            q_ff[s]   <= q_src | (ge ? (DIV_STAGES'(1) << K) : '0);
         end
      end
   end

   assign quo = q_ff[DIV_STAGES-1];

endmodule

// ----- rtl/tdzc_stick.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single stick conditioning pipeline
// Length, unit direction, normalized magnitude and dead zone for one stick.
// ----------------------------------------------------------------------------
module tdzc_stick (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [15:0]     x_raw,
   input  logic signed [15:0]     y_raw,
   input  logic [14:0]            inner,
   input  logic [14:0]            dead_zone,
   input  tdzc_pkg::zone_mode_type zone_mode,
   output logic signed [15:0]     x_out,
   output logic signed [15:0]     y_out,
   output logic [15:0]            mag_out
);
   import tdzc_pkg::*;

   // stage 1: absolute values and squares
   logic [16:0] a_in, b_in;
   logic [33:0] aa_full, bb_full;
   logic [29:0] tt_full;
   logic [16:0] a_ff, b_ff;
   logic        sx_ff, sy_ff;
   logic [30:0] aa_ff, bb_ff;
   logic [29:0] tt_ff;

   assign a_in    = x_raw[15] ? (17'd0 - {1'b1, x_raw}) : {1'b0, x_raw};
   assign b_in    = y_raw[15] ? (17'd0 - {1'b1, y_raw}) : {1'b0, y_raw};
   assign aa_full = a_in * a_in;
   assign bb_full = b_in * b_in;
   assign tt_full = inner * inner;

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         sx_ff <= x_raw[15];
         sy_ff <= y_raw[15];
         aa_ff <= aa_full[30:0];
         bb_ff <= bb_full[30:0];
         tt_ff <= tt_full;
      end
   end

   // stage 2: squared length and inside test
   logic [31:0]   m2_in, m2_ff;
   side_sqrt_type s2_ff;

   assign m2_in = {1'b0, aa_ff} + {1'b0, bb_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         m2_ff     <= m2_in;
         s2_ff.sx  <= sx_ff;
         s2_ff.sy  <= sy_ff;
         s2_ff.a   <= a_ff;
         s2_ff.b   <= b_ff;
         s2_ff.in_zone <= m2_in <= {2'b00, tt_ff};
      end
   end

   // square root with sideband delay line
   logic [23:0]   r;
   side_sqrt_type sq_dly_ff [SQRT_STAGES];

   tdzc_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .m2    (m2_ff),
      .root  (r)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sq_dly_ff[0] <= s2_ff;
         for (int i = 1; i < SQRT_STAGES; i++) sq_dly_ff[i] <= sq_dly_ff[i-1];
      end
   end

   // prep: rounded division operands for direction and magnitude
   side_sqrt_type        sq_side;
   logic [23:0]          mc, t256, mnum, mden;
   logic [DIV_NUM_W-1:0] na_ff, nb_ff, nm_ff;
   logic [DIV_DEN_W-1:0] dr_ff, dm_ff;
   side_div_type         sp_ff;

   assign sq_side = sq_dly_ff[SQRT_STAGES-1];
   assign mc      = (r > FULL_RAW_Q8) ? FULL_RAW_Q8 : r;
   assign t256    = {1'b0, inner, 8'd0};
   assign mnum    = (mc > t256) ? (mc - t256) : 24'd0;
   assign mden    = {1'b0, FULL_RAW - inner, 8'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         na_ff <= {sq_side.a, 24'd0} + DIV_NUM_W'(r);
         nb_ff <= {sq_side.b, 24'd0} + DIV_NUM_W'(r);
         dr_ff <= {r, 1'b0};
         nm_ff <= DIV_NUM_W'({mnum, 16'd0}) + DIV_NUM_W'(mden);
         dm_ff <= DIV_DEN_W'({mden, 1'b0});
         sp_ff.sx     <= sq_side.sx;
         sp_ff.sy     <= sq_side.sy;
         sp_ff.in_zone <= sq_side.in_zone;
         sp_ff.full   <= inner == FULL_RAW;
      end
   end

   // three parallel dividers for da, db and magnitude
   logic [DIV_STAGES-1:0] qa, qb, qm;
   side_div_type          dv_dly_ff [DIV_STAGES];

   tdzc_divider u_div_a (.clock(clock), .en(en), .num(na_ff), .den(dr_ff), .quo(qa));
   tdzc_divider u_div_b (.clock(clock), .en(en), .num(nb_ff), .den(dr_ff), .quo(qb));
   tdzc_divider u_div_m (.clock(clock), .en(en), .num(nm_ff), .den(dm_ff), .quo(qm));

   always_ff @(posedge clock) begin
      if (en) begin
         dv_dly_ff[0] <= sp_ff;
         for (int i = 1; i < DIV_STAGES; i++) dv_dly_ff[i] <= dv_dly_ff[i-1];
      end
   end

   // clamp and dead zone compares
   side_div_type  dv_side;
   logic [16:0]   da_in, db_in, mg_in, dz17;
   side_mode_type c_ff;
   logic [16:0]   diff_ff;
   logic [15:0]   den3_ff;

   assign dv_side = dv_dly_ff[DIV_STAGES-1];
   assign da_in   = (qa > ONE_Q15) ? ONE_Q15 : qa;
   assign db_in   = (qb > ONE_Q15) ? ONE_Q15 : qb;
   assign mg_in   = (dv_side.full || qm > ONE_Q15) ? ONE_Q15 : qm;
   assign dz17    = {2'b00, dead_zone};

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff.sx     <= dv_side.sx;
         c_ff.sy     <= dv_side.sy;
         c_ff.in_zone <= dv_side.in_zone;
         c_ff.za     <= da_in < dz17;
         c_ff.zb     <= db_in < dz17;
         c_ff.zr     <= mg_in < dz17;
         c_ff.da     <= da_in;
         c_ff.db     <= db_in;
         c_ff.mag    <= mg_in;
         diff_ff     <= mg_in - dz17;
         den3_ff     <= 16'(ONE_Q15 - dz17);
      end
   end

   // scaled radial products
   logic [33:0]   pa_full, pb_full;
   logic [30:0]   pa_ff, pb_ff;
   logic [15:0]   den3b_ff;
   side_mode_type p_ff;

   assign pa_full = c_ff.da * diff_ff;
   assign pb_full = c_ff.db * diff_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff    <= pa_full[30:0];
         pb_ff    <= pb_full[30:0];
         den3b_ff <= den3_ff;
         p_ff     <= c_ff;
      end
   end

   // rounding operands for the scale division
   logic [DIV_NUM_W-1:0] sa_ff, sb_ff;
   logic [DIV_DEN_W-1:0] sd_ff;
   side_mode_type        q_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff <= DIV_NUM_W'({pa_ff, 1'b0}) + DIV_NUM_W'(den3b_ff);
         sb_ff <= DIV_NUM_W'({pb_ff, 1'b0}) + DIV_NUM_W'(den3b_ff);
         sd_ff <= DIV_DEN_W'({den3b_ff, 1'b0});
         q_ff  <= p_ff;
      end
   end

   logic [DIV_STAGES-1:0] ka, kb;
   side_mode_type         md_dly_ff [DIV_STAGES];

   tdzc_divider u_div_sa (.clock(clock), .en(en), .num(sa_ff), .den(sd_ff), .quo(ka));
   tdzc_divider u_div_sb (.clock(clock), .en(en), .num(sb_ff), .den(sd_ff), .quo(kb));

   always_ff @(posedge clock) begin
      if (en) begin
         md_dly_ff[0] <= q_ff;
         for (int i = 1; i < DIV_STAGES; i++) md_dly_ff[i] <= md_dly_ff[i-1];
      end
   end

   // mode select, sign and saturation
   side_mode_type     fs;
   logic [16:0]       ua, ub;
   logic signed [15:0] x_in, y_in;
   logic signed [15:0] x_ff, y_ff;
   logic [15:0]       mag_ff;

   assign fs = md_dly_ff[DIV_STAGES-1];

   always_comb begin
      case (zone_mode)
         MODE_NONE: begin
            ua = fs.da;
            ub = fs.db;
         end
         MODE_AXIAL: begin
            ua = fs.za ? 17'd0 : fs.da;
            ub = fs.zb ? 17'd0 : fs.db;
         end
         MODE_RADIAL: begin
            ua = fs.zr ? 17'd0 : fs.da;
            ub = fs.zr ? 17'd0 : fs.db;
         end
         MODE_SCALED: begin
            ua = fs.zr ? 17'd0 : ka;
            ub = fs.zr ? 17'd0 : kb;
         end
         default: begin
            ua = fs.da;
            ub = fs.db;
         end
      endcase
      if (fs.in_zone) begin
         x_in = '0;
         y_in = '0;
      end else begin
         if (fs.sx) x_in = 16'(17'd0 - ua);
         else       x_in = (ua > 17'd32767) ? 16'sd32767 : 16'(ua);
         if (fs.sy) y_in = 16'(17'd0 - ub);
         else       y_in = (ub > 17'd32767) ? 16'sd32767 : 16'(ub);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         mag_ff <= fs.in_zone ? 16'd0 : fs.mag[15:0];
      end
   end

   assign x_out   = x_ff;
   assign y_out   = y_ff;
   assign mag_out = mag_ff;

endmodule

// ----- rtl/thumbstick_dead_zone_conditioner_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thumbstick dead zone conditioner core
// Two-stick radial dead zone conditioning, fully pipelined, one word a cycle.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one raw sample of both sticks per word; rsp_* returns the
//  conditioned directions and magnitudes of that sample, in order.
//  csr_* writes the mode, dead zone and per-stick inner thresholds; it is
//  always ready. Write it only while no word is in flight.
//  A word runs from req accept to rsp valid through 65 pipeline stages
//  (24-stage square root, two 17-stage dividers in series, multiply and
//  select stages) plus the output register.
//  Throughput is one word per cycle while rsp_tready stays high.
//  Reset clears all valid bits and restores the register defaults
//  (scaled radial, dead zone 3277, inner thresholds 7849 and 8689).
//  When the receiver stalls, one more word lands in a skid register and then
//  the whole pipeline freezes with req_tready low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module thumbstick_dead_zone_conditioner_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // left_x_raw, left_y_raw, right_x_raw, right_y_raw
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // left_x_out, left_y_out, right_x_out, right_y_out,
   // left_magnitude, right_magnitude
   output logic [95:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tdzc_pkg::*;

   // configuration registers
   zone_mode_type mode_ff;
   logic [14:0]   dz_ff, lt_ff, rt_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SCALED;
         dz_ff   <= DEAD_ZONE_RST;
         lt_ff   <= LEFT_INNER_RST;
         rt_ff   <= RIGHT_INNER_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ZONE_MODE:   mode_ff <= zone_mode_type'(csr_wdata[1:0]);
            CSR_DEAD_ZONE:   dz_ff   <= csr_wdata[14:0];
            CSR_LEFT_INNER:  lt_ff   <= csr_wdata[14:0];
            CSR_RIGHT_INNER: rt_ff   <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // pipeline advances unless the skid register is occupied
   logic en;
   logic skid_v_ff, out_v_ff;
   logic [STICK_LAT-1:0] vld_ff;

   assign en         = !skid_v_ff;
   assign req_tready = en;

   logic signed [15:0] lx, ly, rx, ry;
   logic [15:0]        lm, rm;
   logic [95:0]        pipe_word;

   tdzc_stick u_left (
      .clock     (clock),
      .en        (en),
      .x_raw     (req_tdata[15:0]),
      .y_raw     (req_tdata[31:16]),
      .inner     (lt_ff),
      .dead_zone (dz_ff),
      .zone_mode (mode_ff),
      .x_out     (lx),
      .y_out     (ly),
      .mag_out   (lm)
   );

   tdzc_stick u_right (
      .clock     (clock),
      .en        (en),
      .x_raw     (req_tdata[47:32]),
      .y_raw     (req_tdata[63:48]),
      .inner     (rt_ff),
      .dead_zone (dz_ff),
      .zone_mode (mode_ff),
      .x_out     (rx),
      .y_out     (ry),
      .mag_out   (rm)
   );

   assign pipe_word = {rm, lm, ry, rx, ly, lx};

   // valid line and output / skid control
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (en) vld_ff <= {vld_ff[STICK_LAT-2:0], req_tvalid};
         if (!out_v_ff || rsp_tready) begin
            if (skid_v_ff) begin
               out_v_ff  <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= en && vld_ff[STICK_LAT-1];
            end
         end else if (en && vld_ff[STICK_LAT-1]) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   // output and skid payload
   logic [95:0] out_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) out_ff <= skid_v_ff ? skid_ff : pipe_word;
      if (out_v_ff && !rsp_tready && en) skid_ff <= pipe_word;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

endmodule

// ----- rtl/tdzc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thumbstick dead zone conditioner port checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "thumbstick_dead_zone_conditioner_core_defines.svh"

module tdzc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   // stalled word holds
   `TDZC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp word changed under stall")

   // no result right after reset
   `TDZC_ASSERT_NR(a_rst_empty, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

   // input backpressure only follows an output stall
   `TDZC_ASSERT(a_bp_cause, clock, reset, !req_tready && !$past(reset) |-> $past(rsp_tvalid && !rsp_tready), "req stalled without rsp stall")

   // magnitudes never exceed 1.0
   `TDZC_ASSERT(a_mag_range, clock, reset, rsp_tvalid |-> (rsp_tdata[79:64] <= 16'd32768) && (rsp_tdata[95:80] <= 16'd32768), "magnitude above one")

endmodule

bind thumbstick_dead_zone_conditioner_core tdzc_checker u_tdzc_checker (.*);
